// ===== rtl/core/c_subset_token_lexer_macros.svh =====
// Assertion macros shared by the lexer modules.
`ifndef C_SUBSET_TOKEN_LEXER_MACROS_SVH
`define C_SUBSET_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CSTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cstl_pkg.sv =====
// Types, token codes and constants for the C subset lexer.
package cstl_pkg;

    localparam int MAX_ID_CHARS = 8;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [30:0] LIT_MAX = 31'h7FFF_FFFF;

    localparam logic [63:0] KW_RETURN_TEXT = 64'h0000_6E72_7574_6572;
    localparam logic [3:0]  KW_RETURN_LEN  = 4'd6;
    localparam logic [63:0] KW_INT_TEXT    = 64'h0000_0000_0074_6E69;
    localparam logic [3:0]  KW_INT_LEN     = 4'd3;
    localparam logic [63:0] KW_VOID_TEXT   = 64'h0000_0000_6469_6F76;
    localparam logic [3:0]  KW_VOID_LEN    = 4'd4;

    typedef enum logic [4:0] {
        K_LBRACE, K_RBRACE, K_LPAREN, K_RPAREN, K_SEMI, K_COMMA, K_MINUS, K_PLUS,
        K_STAR, K_SLASH, K_TILDE, K_NE, K_BANG, K_LE, K_SHL, K_LT,
        K_GE, K_SHR, K_GT, K_LAND, K_AMP, K_LOR, K_BAR, K_EQ,
        K_ASSIGN, K_PERCENT, K_CARET, K_LIT, K_RETURN, K_INT, K_VOID, K_ID
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [30:0] int_value;
        logic [63:0] id_text;
        logic [3:0]  id_length;
        logic        id_truncated;
        logic        int_overflow;
        logic        last;
    } token_t;

    // Tokens produced by one accepted byte, in output order.
    typedef struct packed {
        logic   tok0_valid;
        logic   tok1_valid;
        token_t tok0;
        token_t tok1;
    } push_t;

endpackage

// ===== rtl/core/cstl_lex_core.sv =====
// Lexer state and per-byte token generation.
`include "c_subset_token_lexer_macros.svh"

module cstl_lex_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      ch,
    input  logic            end_of_file,
    output cstl_pkg::push_t push
);
    import cstl_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PEND,
        MODE_NUM,
        MODE_WORD
    } mode_t;

    typedef struct packed {
        logic      hit;
        tok_kind_t kind;
    } kind_hit_t;

    function automatic kind_hit_t single_kind(input logic [7:0] c);
        kind_hit_t r;
        r.hit = 1'b1;
        unique case (c)
            8'h7B:   r.kind = K_LBRACE;
            8'h7D:   r.kind = K_RBRACE;
            8'h28:   r.kind = K_LPAREN;
            8'h29:   r.kind = K_RPAREN;
            8'h3B:   r.kind = K_SEMI;
            8'h2C:   r.kind = K_COMMA;
            8'h2D:   r.kind = K_MINUS;
            8'h2B:   r.kind = K_PLUS;
            8'h2A:   r.kind = K_STAR;
            8'h2F:   r.kind = K_SLASH;
            8'h7E:   r.kind = K_TILDE;
            8'h21:   r.kind = K_BANG;
            8'h3C:   r.kind = K_LT;
            8'h3E:   r.kind = K_GT;
            8'h26:   r.kind = K_AMP;
            8'h7C:   r.kind = K_BAR;
            8'h3D:   r.kind = K_ASSIGN;
            8'h25:   r.kind = K_PERCENT;
            8'h5E:   r.kind = K_CARET;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = K_LBRACE;
            end
        endcase
        return r;
    endfunction

    function automatic logic may_pair(input logic [7:0] c);
        return (c == 8'h21) || (c == 8'h3C) || (c == 8'h3E) ||
               (c == 8'h26) || (c == 8'h7C) || (c == 8'h3D);
    endfunction

    function automatic kind_hit_t pair_kind(input logic [7:0] a, input logic [7:0] b);
        kind_hit_t r;
        r.hit  = 1'b1;
        r.kind = K_LBRACE;
        priority if (a == 8'h21 && b == 8'h3D) r.kind = K_NE;
        else if (a == 8'h3C && b == 8'h3D)     r.kind = K_LE;
        else if (a == 8'h3C && b == 8'h3C)     r.kind = K_SHL;
        else if (a == 8'h3E && b == 8'h3D)     r.kind = K_GE;
        else if (a == 8'h3E && b == 8'h3E)     r.kind = K_SHR;
        else if (a == 8'h26 && b == 8'h26)     r.kind = K_LAND;
        else if (a == 8'h7C && b == 8'h7C)     r.kind = K_LOR;
        else if (a == 8'h3D && b == 8'h3D)     r.kind = K_EQ;
        else                                   r.hit  = 1'b0;
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [7:0]  pending_reg, pending_next;
    logic [30:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [63:0] chars_reg, chars_next;
    logic [3:0]  len_reg, len_next;
    logic        trunc_reg, trunc_next;

    logic        is_digit;
    logic        is_letter;
    logic [34:0] acc_times10;
    kind_hit_t   pend_single;
    kind_hit_t   pair_hit;
    kind_hit_t   fresh_single;
    token_t      flush_tok;
    token_t      pair_tok;
    token_t      fresh_tok;
    token_t      tok_a;
    token_t      tok_b;
    logic        a_valid;
    logic        b_valid;

    assign is_digit  = (ch >= 8'd48) && (ch <= 8'd57);
    assign is_letter = ((ch >= 8'd65) && (ch <= 8'd90)) || ((ch >= 8'd97) && (ch <= 8'd122));
    assign acc_times10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {31'b0, ch[3:0]};

    assign pend_single  = single_kind(pending_reg);
    assign pair_hit     = pair_kind(pending_reg, ch);
    assign fresh_single = single_kind(ch);

    // Token that closes whatever is in progress.
    always_comb
    begin
        flush_tok      = '0;
        flush_tok.kind = pend_single.kind;
        unique case (mode_reg)
            MODE_NUM:
            begin
                flush_tok.kind         = K_LIT;
                flush_tok.int_value    = acc_reg;
                flush_tok.int_overflow = ovf_reg;
            end
            MODE_WORD:
            begin
                priority if (!trunc_reg && len_reg == KW_RETURN_LEN &&
                             chars_reg == KW_RETURN_TEXT)
                    flush_tok.kind = K_RETURN;
                else if (!trunc_reg && len_reg == KW_INT_LEN && chars_reg == KW_INT_TEXT)
                    flush_tok.kind = K_INT;
                else if (!trunc_reg && len_reg == KW_VOID_LEN && chars_reg == KW_VOID_TEXT)
                    flush_tok.kind = K_VOID;
                else
                begin
                    flush_tok.kind         = K_ID;
                    flush_tok.id_text      = chars_reg;
                    flush_tok.id_length    = len_reg;
                    flush_tok.id_truncated = trunc_reg;
                end
            end
            MODE_IDLE, MODE_PEND: ;
            default: ;
        endcase

        pair_tok       = '0;
        pair_tok.kind  = pair_hit.kind;
        fresh_tok      = '0;
        fresh_tok.kind = fresh_single.kind;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        chars_next   = chars_reg;
        len_next     = len_reg;
        trunc_next   = trunc_reg;
        tok_a        = flush_tok;
        tok_b        = fresh_tok;
        a_valid      = 1'b0;
        b_valid      = 1'b0;

        priority if (end_of_file)
        begin
            a_valid   = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
        end
        else if (mode_reg == MODE_PEND && pair_hit.hit)
        begin
            tok_a     = pair_tok;
            a_valid   = 1'b1;
            mode_next = MODE_IDLE;
        end
        else if (mode_reg == MODE_NUM && is_digit)
        begin
            if (acc_times10 > {4'b0, LIT_MAX})
            begin
                acc_next = LIT_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = acc_times10[30:0];
            end
        end
        else if (mode_reg == MODE_WORD && is_letter)
        begin
            if (len_reg < 4'(MAX_ID_CHARS))
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (len_reg[2:0] == 3'(i))
                        chars_next[8*i +: 8] = ch;
                end
                len_next = len_reg + 4'd1;
            end
            else
            begin
                trunc_next = 1'b1;
            end
        end
        else
        begin
            // Close the current token, then treat this byte as a fresh start.
            a_valid   = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            priority if (is_digit)
            begin
                mode_next = MODE_NUM;
                acc_next  = {27'b0, ch[3:0]};
                ovf_next  = 1'b0;
            end
            else if (is_letter)
            begin
                mode_next  = MODE_WORD;
                chars_next = {56'b0, ch};
                len_next   = 4'd1;
                trunc_next = 1'b0;
            end
            else if (may_pair(ch))
            begin
                mode_next    = MODE_PEND;
                pending_next = ch;
            end
            else
            begin
                b_valid = fresh_single.hit;
            end
        end
    end

    // Pack the results so the first valid token is always in slot 0.
    always_comb
    begin
        push.tok0_valid = accept && (a_valid || b_valid);
        push.tok1_valid = accept && a_valid && b_valid;
        push.tok0       = a_valid ? tok_a : tok_b;
        push.tok0.last  = !(a_valid && b_valid);
        push.tok1       = tok_b;
        push.tok1.last  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pending_reg <= '0;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            chars_reg   <= '0;
            len_reg     <= '0;
            trunc_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            chars_reg   <= chars_next;
            len_reg     <= len_next;
            trunc_reg   <= trunc_next;
        end
    end

    `CSTL_ASSERT_NOW(a_slot_order, push.tok1_valid, push.tok0_valid,
        "second token without a first")
    `CSTL_ASSERT_NOW(a_word_len, mode_reg == MODE_WORD,
        (len_reg >= 4'd1) && (len_reg <= 4'(MAX_ID_CHARS)), "word length out of range")
    `CSTL_ASSERT_NOW(a_ovf_sat, ovf_reg && mode_reg == MODE_NUM, acc_reg == LIT_MAX,
        "overflowed literal not saturated")

endmodule

// ===== rtl/core/cstl_out_fifo.sv =====
// Token queue: takes up to two tokens per cycle, hands out one per transfer.
`include "c_subset_token_lexer_macros.svh"

module cstl_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  cstl_pkg::push_t  push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output cstl_pkg::token_t out_tok
);
    import cstl_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    token_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wptr_plus1;
    logic               pop;
    logic [1:0]         push_n;

    assign wptr_plus1 = wptr_reg + PTR_W'(1);
    assign pop        = out_valid && out_ready;
    assign push_n     = {1'b0, push.tok0_valid} + {1'b0, push.tok1_valid};
    assign count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[rptr_reg];
    // Space for the worst case of two tokens from the next byte.
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.tok0_valid)
            mem[wptr_reg] <= push.tok0;
        if (push.tok1_valid)
            mem[wptr_plus1] <= push.tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + PTR_W'(push_n);
            rptr_reg  <= rptr_reg + PTR_W'(pop);
            count_reg <= count_next;
        end
    end

    `CSTL_ASSERT_NOW(a_no_overrun, push_n != 2'd0,
        ({1'b0, count_reg} + {{CNT_W-1{1'b0}}, push_n}) <= (CNT_W+1)'(FIFO_DEPTH),
        "token queue overrun")
    `CSTL_ASSERT_NOW(a_push_order, push.tok1_valid, push.tok0_valid,
        "second slot written without the first")
    `CSTL_ASSERT_NEXT(a_count_two, count_reg == '0 && push_n == 2'd2,
        count_reg == CNT_W'(2), "double push into empty queue lost a token")

endmodule

// ===== rtl/core/c_subset_token_lexer.sv =====
// C subset lexer: one source byte in per transfer, tokens out in order.
// The lexer takes one byte (or end mark) in every cycle while the queue has room; each byte
// is decoded combinationally against the held lexer state and its 0, 1 or 2 tokens go into
// a 4-entry token queue. Tokens leave at one per cycle while the receiver is ready, so a
// byte that both closes a token and emits a single-character one yields two output
// transfers; input is held off only while the queue lacks room for two more tokens.
// Identifiers keep their first 8 bytes; literals saturate at 2147483647.
module c_subset_token_lexer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tuser,   // [0] end_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [30:0] int_value, [94:31] id_text, [98:95] id_length,
                                    // [99] id_truncated, [100] int_overflow, [103:101] zero
    output logic [4:0]   m_tuser,   // [4:0] token_kind
    output logic         m_tlast
);
    import cstl_pkg::*;

    logic   accept;
    logic   room;
    push_t  push;
    token_t tok;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    cstl_lex_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ch          (s_tdata),
        .end_of_file (s_tuser),
        .push        (push)
    );

    cstl_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok)
    );

    assign m_tdata = {3'b000, tok.int_overflow, tok.id_truncated, tok.id_length,
                      tok.id_text, tok.int_value};
    assign m_tuser = tok.kind;
    assign m_tlast = tok.last;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the C subset token lexer: byte stream in, token stream checked.
`timescale 1ns / 100ps

module tb_top;
    import cstl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int CALM_AFTER     = 1000;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_OP, SCAN_NUM, SCAN_WORD} scan_mode_t;

    // Tracks lexer state for every accepted byte and queues the tokens it must produce.
    class token_tracker;
        scan_mode_t  mode;
        logic [7:0]  op_char;
        logic [30:0] num;
        logic        num_ovf;
        logic [63:0] word;
        logic [3:0]  wlen;
        logic        wtrunc;
        token_t      tokens_due[$];
        token_t      fresh[$];
        int          failures;

        function new();
            mode     = SCAN_IDLE;
            op_char  = '0;
            num      = '0;
            num_ovf  = 1'b0;
            word     = '0;
            wlen     = '0;
            wtrunc   = 1'b0;
            failures = 0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function void add(tok_kind_t k, logic [30:0] v = '0, logic [63:0] txt = '0,
                          logic [3:0] len = '0, logic tr = 1'b0, logic ov = 1'b0);
            token_t t;
            t.kind         = k;
            t.int_value    = v;
            t.id_text      = txt;
            t.id_length    = len;
            t.id_truncated = tr;
            t.int_overflow = ov;
            t.last         = 1'b0;
            fresh.insert(fresh.size(), t);
        endfunction

        function bit single_op(logic [7:0] c, output tok_kind_t k);
            single_op = 1'b1;
            k = K_LBRACE;
            case (c)
                "{": k = K_LBRACE;
                "}": k = K_RBRACE;
                "(": k = K_LPAREN;
                ")": k = K_RPAREN;
                ";": k = K_SEMI;
                ",": k = K_COMMA;
                "-": k = K_MINUS;
                "+": k = K_PLUS;
                "*": k = K_STAR;
                "/": k = K_SLASH;
                "~": k = K_TILDE;
                "!": k = K_BANG;
                "<": k = K_LT;
                ">": k = K_GT;
                "&": k = K_AMP;
                "|": k = K_BAR;
                "=": k = K_ASSIGN;
                "%": k = K_PERCENT;
                "^": k = K_CARET;
                default: single_op = 1'b0;
            endcase
        endfunction

        function bit pair_op(logic [7:0] a, logic [7:0] b, output tok_kind_t k);
            pair_op = 1'b1;
            k = K_NE;
            case ({a, b})
                "!=": k = K_NE;
                "<=": k = K_LE;
                "<<": k = K_SHL;
                ">=": k = K_GE;
                ">>": k = K_SHR;
                "&&": k = K_LAND;
                "||": k = K_LOR;
                "==": k = K_EQ;
                default: pair_op = 1'b0;
            endcase
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function void close_token();
            tok_kind_t k;
            case (mode)
                SCAN_OP:
                begin
                    if (single_op(op_char, k))
                        add(k);
                end
                SCAN_NUM: add(K_LIT, num, '0, '0, 1'b0, num_ovf);
                SCAN_WORD:
                begin
                    // a truncated word never matches a keyword
                    if (!wtrunc && wlen == KW_RETURN_LEN && word == KW_RETURN_TEXT)
                        add(K_RETURN);
                    else if (!wtrunc && wlen == KW_INT_LEN && word == KW_INT_TEXT)
                        add(K_INT);
                    else if (!wtrunc && wlen == KW_VOID_LEN && word == KW_VOID_TEXT)
                        add(K_VOID);
                    else
                        add(K_ID, '0, word, wlen, wtrunc, 1'b0);
                end
                default: ;
            endcase
            mode = SCAN_IDLE;
        endfunction

        function void begin_token(logic [7:0] c);
            tok_kind_t k;
            mode = SCAN_IDLE;
            if (is_digit(c))
            begin
                mode    = SCAN_NUM;
                num     = {23'd0, c - 8'd48};
                num_ovf = 1'b0;
            end
            else if (is_letter(c))
            begin
                mode   = SCAN_WORD;
                word   = {56'd0, c};
                wlen   = 4'd1;
                wtrunc = 1'b0;
            end
            else if (c inside {"!", "<", ">", "&", "|", "="})
            begin
                mode    = SCAN_OP;
                op_char = c;
            end
            else if (single_op(c, k))
            begin
                add(k);
            end
        endfunction

        function void note_byte(logic [7:0] c, logic eof);
            tok_kind_t   k;
            logic [34:0] grown;
            fresh.delete();
            if (eof)
            begin
                close_token();
            end
            else if (mode == SCAN_OP)
            begin
                if (pair_op(op_char, c, k))
                begin
                    add(k);
                    mode = SCAN_IDLE;
                end
                else
                begin
                    // failed pair: emit the single, then lex this byte afresh
                    close_token();
                    begin_token(c);
                end
            end
            else if (mode == SCAN_NUM && is_digit(c))
            begin
                grown = {4'd0, num} * 35'd10 + {27'd0, c - 8'd48};
                if (grown > {4'd0, LIT_MAX})
                begin
                    num     = LIT_MAX;
                    num_ovf = 1'b1;
                end
                else
                begin
                    num = grown[30:0];
                end
            end
            else if (mode == SCAN_WORD && is_letter(c))
            begin
                if (wlen < MAX_ID_CHARS)
                begin
                    word[8 * wlen +: 8] = c;
                    wlen = wlen + 4'd1;
                end
                else
                begin
                    wtrunc = 1'b1;
                end
            end
            else
            begin
                close_token();
                begin_token(c);
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                tokens_due.insert(tokens_due.size(), fresh[i]);
        endfunction

        function void complain(string what, token_t exp, token_t got);
            failures++;
            if (failures <= 10)
                $display("%s: expected kind %0d value %0d text %h len %0d trunc %b ovf %b last %b",
                         what, exp.kind, exp.int_value, exp.id_text, exp.id_length,
                         exp.id_truncated, exp.int_overflow, exp.last);
            if (failures <= 10)
                $display("    got kind %0d value %0d text %h len %0d trunc %b ovf %b last %b",
                         got.kind, got.int_value, got.id_text, got.id_length,
                         got.id_truncated, got.int_overflow, got.last);
        endfunction

        function void check_token(token_t got);
            token_t exp;
            if (tokens_due.size() == 0)
            begin
                complain("token with none expected", '0, got);
                return;
            end
            exp = tokens_due.pop_front();
            if (got.kind !== exp.kind || got.int_value !== exp.int_value ||
                got.id_text !== exp.id_text || got.id_length !== exp.id_length ||
                got.id_truncated !== exp.id_truncated || got.int_overflow !== exp.int_overflow ||
                got.last !== exp.last)
                complain("token mismatch", exp, got);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] ch
    logic         s_tuser;   // [0] end_of_file
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // [30:0] int_value, [94:31] id_text, [98:95] id_length,
                             // [99] id_truncated, [100] int_overflow, [103:101] zero
    logic [4:0]   m_tuser;   // [4:0] token_kind
    logic         m_tlast;

    token_tracker tracker;
    token_t       seen_tok;
    int           items_sent;
    int           idle_cycles;
    bit           calm;
    bit           hold_done;
    bit           pause_done;

    c_subset_token_lexer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [7:0] c, input logic eof);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_byte(c, eof);
        items_sent++;
        calm = items_sent >= CALM_AFTER;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] r;
        r = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) ? "A" : "a") + r;
    endfunction

    // Mostly well-formed tokens, some noise bytes and end marks, optional whitespace after.
    task automatic send_random_token();
        int    pick;
        int    count;
        string ops;
        ops  = "{}();,-+*/~%^!<>&|=";
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            send_item(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
        end
        else if (pick < 34)
        begin
            case ($urandom_range(0, 7))
                0: send_text("!=");
                1: send_text("<=");
                2: send_text("<<");
                3: send_text(">=");
                4: send_text(">>");
                5: send_text("&&");
                6: send_text("||");
                default: send_text("==");
            endcase
        end
        else if (pick < 44)
        begin
            case ($urandom_range(0, 2))
                0: send_text("return");
                1: send_text("int");
                default: send_text("void");
            endcase
        end
        else if (pick < 64)
        begin
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            repeat (count) send_item(rand_letter(), 1'b0);
        end
        else if (pick < 82)
        begin
            case ($urandom_range(0, 7))
                0: send_text("2147483647");
                1: send_text("2147483648");
                2: send_text("99999999999");
                default:
                begin
                    count = $urandom_range(1, 10);
                    repeat (count) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
            endcase
        end
        else if (pick < 92)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        case ($urandom_range(0, 5))
            0: send_item(" ", 1'b0);
            1: send_item(8'h0A, 1'b0);
            2: send_item(8'h09, 1'b0);
            default: ;
        endcase
    endtask

    initial
    begin : stim
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        items_sent = 0;
        calm       = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        tracker    = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // chained pair, failed pairs, over-long word, overflowing literal, kind switches
        send_text("<<=!xabcdefgh");
        send_text("2147483648");
        send_text("Z");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("=");
        send_item(8'hA5, 1'b1);
        send_item(8'h5A, 1'b1);   // end mark while idle

        while (items_sent < RANDOM_ITEMS)
        begin
            send_random_token();
            if (!hold_done && items_sent >= 400)
                hold_done = 1'b1;
            if (!pause_done && items_sent >= 700)
            begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (tracker.pending() != 0);
            end
        end
        send_item(8'h00, 1'b1);
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("c_subset_token_lexer test passed");
        else
            $display("c_subset_token_lexer test failed");
        $finish;
    end

    initial
    begin : rx_side
        int n;
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_done && !hold_taken)
            begin
                // long hold-off so the token queue fills and back-pressures the input
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                n = HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 9);
            end
            else
            begin
                m_tready <= 1'b1;
                n = 1;
            end
            repeat (n) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_tok.kind         = tok_kind_t'(m_tuser);
            seen_tok.int_value    = m_tdata[30:0];
            seen_tok.id_text      = m_tdata[94:31];
            seen_tok.id_length    = m_tdata[98:95];
            seen_tok.id_truncated = m_tdata[99];
            seen_tok.int_overflow = m_tdata[100];
            seen_tok.last         = m_tlast;
            tracker.check_token(seen_tok);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("c_subset_token_lexer test failed");
            $finish;
        end
    end

endmodule
